FILE: rtl/sar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sar_pkg;

    localparam int UV_W     = 23;
    localparam int DATA_W   = 8;
    localparam int ADDR_W   = 3;
    localparam int MODE_W   = 2;
    localparam int RES_W    = 16;
    localparam int CODE_W   = 10;
    localparam int TICK_W   = 11;
    localparam int CFG_IDX_W = 1;

    // Divider: numerator is uV * 512, divisor is half the reference.
    localparam int NUM_SHIFT = 9;
    localparam int DIV_W     = UV_W + NUM_SHIFT;
    localparam int DIV_STEPS = CODE_W + 1;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int LJ_SHIFT  = RES_W - CODE_W;

    localparam logic [UV_W-1:0] AREF_RESET = UV_W'(2500000);
    localparam logic [UV_W-1:0] AVCC_RESET = UV_W'(5000000);
    localparam logic [UV_W-1:0] REF_1V1    = UV_W'(1100000);
    localparam logic [UV_W-1:0] REF_2V56   = UV_W'(2560000);
    localparam logic [CODE_W-1:0] MAX_CODE = CODE_W'(1023);
    localparam logic [4:0] MAX_CHANNEL     = 5'd6;

    // Control/status and mux bit positions
    localparam int BIT_EN = 7;
    localparam int BIT_SC = 6;
    localparam int BIT_IF = 4;
    localparam int BIT_IE = 3;
    localparam int BIT_LEFT = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_TICK  = 2'd2,
        MODE_ACK   = 2'd3
    } mode_t;

    typedef enum logic [ADDR_W-1:0] {
        ADDR_RES_LO = 3'd0,
        ADDR_RES_HI = 3'd1,
        ADDR_CSR    = 3'd2,
        ADDR_CTRLB  = 3'd3,
        ADDR_MUX    = 3'd4
    } addr_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AREF = 1'd0,
        CFG_AVCC = 1'd1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REFS_EXT  = 2'd0,
        REFS_VCC  = 2'd1,
        REFS_1V1  = 2'd2,
        REFS_2V56 = 2'd3
    } refs_t;

    typedef struct packed {
        logic take;      // request accepted this cycle
        logic div_load;  // sampling tick: load divider operands
        logic div_step;  // one restoring division step
        logic div_last;  // final step, write back result
    } cmd_t;

    typedef struct packed {
        logic sample_hit; // present request is the sampling tick
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/sar_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sar_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire sar_pkg::status_t sts,
    output sar_pkg::cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [sar_pkg::STEP_W-1:0] step_reg, step_next;
    logic out_valid_reg, out_valid_next;
    logic take;

    assign s_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign take    = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        cmd.take      = take;
        cmd.div_load  = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.div_last  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (take && sts.sample_hit) begin
                    cmd.div_load = 1'b1;
                    step_next    = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == sar_pkg::STEP_W'(sar_pkg::DIV_STEPS - 1)) begin
                    cmd.div_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (take) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sar_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sar_dp (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [sar_pkg::MODE_W-1:0]       s_mode,
    input  wire logic [sar_pkg::ADDR_W-1:0]       s_reg_addr,
    input  wire logic [sar_pkg::DATA_W-1:0]       s_write_data,
    input  wire logic [sar_pkg::UV_W-1:0]         s_channel_uvolt,
    input  wire logic                             cfg_we,
    input  wire logic [sar_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sar_pkg::UV_W-1:0]         cfg_wdata,
    input  wire sar_pkg::cmd_t                    cmd,
    output sar_pkg::status_t                      sts,
    output logic [sar_pkg::DATA_W-1:0]            m_read_data,
    output logic                                  m_irq
);

    localparam int DW = sar_pkg::DATA_W;

    // Architectural state
    logic [sar_pkg::UV_W-1:0]   aref_reg, aref_next;
    logic [sar_pkg::UV_W-1:0]   avcc_reg, avcc_next;
    logic [sar_pkg::RES_W-1:0]  result_reg, result_next;
    logic [DW-1:0]              csr_reg, csr_next;
    logic [DW-1:0]              ctrlb_reg, ctrlb_next;
    logic [DW-1:0]              mux_reg, mux_next;
    logic [sar_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [DW-1:0]              div_reg, div_next;
    logic                       conv_reg, conv_next;
    logic                       sampled_reg, sampled_next;

    // Divider and output payload
    logic [sar_pkg::DIV_W-1:0]  rem_reg, rem_next;
    logic [sar_pkg::DIV_W-1:0]  dvs_reg, dvs_next;
    logic [sar_pkg::CODE_W:0]   quo_reg, quo_next;
    logic                       left_reg, left_next;
    logic [DW-1:0]              rd_reg, rd_next;
    logic                       irq_reg, irq_next;

    logic [sar_pkg::TICK_W-1:0] tick_inc;
    logic [sar_pkg::TICK_W-1:0] sample_at;
    logic [sar_pkg::TICK_W-1:0] done_at;
    logic [sar_pkg::UV_W-1:0]   ref_uv;
    logic [sar_pkg::UV_W-1:0]   volts;
    logic                       rem_ge;
    logic [sar_pkg::CODE_W:0]   quo_fin;
    logic [sar_pkg::CODE_W-1:0] code;
    logic                       is_tick;
    logic [DW-1:0]              keep_if;
    logic [DW-1:0]              wv;

    assign tick_inc  = tick_reg + 1'b1;
    assign sample_at = sar_pkg::TICK_W'(div_reg) + sar_pkg::TICK_W'(div_reg >> 1);
    assign done_at   = sar_pkg::TICK_W'(div_reg) * sar_pkg::TICK_W'(13);
    assign is_tick   = (sar_pkg::mode_t'(s_mode) == sar_pkg::MODE_TICK);

    assign sts.sample_hit = is_tick && conv_reg && !sampled_reg && (tick_inc == sample_at);

    always_comb begin
        unique case (sar_pkg::refs_t'(mux_reg[7:6]))
            sar_pkg::REFS_EXT:  ref_uv = aref_reg;
            sar_pkg::REFS_VCC:  ref_uv = avcc_reg;
            sar_pkg::REFS_1V1:  ref_uv = sar_pkg::REF_1V1;
            sar_pkg::REFS_2V56: ref_uv = sar_pkg::REF_2V56;
            default:            ref_uv = aref_reg;
        endcase
    end

    assign volts   = (mux_reg[4:0] <= sar_pkg::MAX_CHANNEL) ? s_channel_uvolt : '0;
    assign rem_ge  = (rem_reg >= dvs_reg);
    assign quo_fin = {quo_reg[sar_pkg::CODE_W-1:0], rem_ge};
    assign code    = quo_fin[sar_pkg::CODE_W] ? sar_pkg::MAX_CODE
                                              : quo_fin[sar_pkg::CODE_W-1:0];

    assign wv      = s_write_data;
    assign keep_if = {3'b000, csr_reg[sar_pkg::BIT_IF] & ~wv[sar_pkg::BIT_IF], 4'b0000};

    always_comb begin
        aref_next    = aref_reg;
        avcc_next    = avcc_reg;
        result_next  = result_reg;
        csr_next     = csr_reg;
        ctrlb_next   = ctrlb_reg;
        mux_next     = mux_reg;
        tick_next    = tick_reg;
        div_next     = div_reg;
        conv_next    = conv_reg;
        sampled_next = sampled_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        quo_next     = quo_reg;
        left_next    = left_reg;
        rd_next      = rd_reg;
        irq_next     = irq_reg;

        if (cfg_we) begin
            case (sar_pkg::cfg_idx_t'(cfg_index))
                sar_pkg::CFG_AREF: aref_next = cfg_wdata;
                sar_pkg::CFG_AVCC: avcc_next = cfg_wdata;
                default: ;
            endcase
        end

        if (cmd.take) begin
            rd_next = '0;
            unique case (sar_pkg::mode_t'(s_mode))
                sar_pkg::MODE_READ: begin
                    unique case (s_reg_addr)
                        sar_pkg::ADDR_RES_LO: rd_next = result_reg[DW-1:0];
                        sar_pkg::ADDR_RES_HI: rd_next = result_reg[2*DW-1:DW];
                        sar_pkg::ADDR_CSR:    rd_next = csr_reg;
                        sar_pkg::ADDR_CTRLB:  rd_next = ctrlb_reg;
                        sar_pkg::ADDR_MUX:    rd_next = mux_reg;
                        default:              rd_next = '0;
                    endcase
                end
                sar_pkg::MODE_WRITE: begin
                    unique case (s_reg_addr)
                        sar_pkg::ADDR_CSR: begin
                            csr_next = (wv & ~(DW'(1) << sar_pkg::BIT_IF)
                                           & ~(DW'(1) << sar_pkg::BIT_SC)) | keep_if;
                            if (!wv[sar_pkg::BIT_EN]) begin
                                conv_next    = 1'b0;
                                sampled_next = 1'b0;
                            end else if (conv_reg) begin
                                csr_next[sar_pkg::BIT_SC] = 1'b1;
                            end else if (wv[sar_pkg::BIT_SC]) begin
                                div_next     = (wv[2:0] == 3'd0) ? DW'(2)
                                                                 : (DW'(1) << wv[2:0]);
                                tick_next    = '0;
                                conv_next    = 1'b1;
                                sampled_next = 1'b0;
                                csr_next[sar_pkg::BIT_SC] = 1'b1;
                            end
                        end
                        sar_pkg::ADDR_CTRLB: ctrlb_next = wv;
                        sar_pkg::ADDR_MUX:   mux_next   = wv;
                        default: ;
                    endcase
                end
                sar_pkg::MODE_TICK: begin
                    if (conv_reg) begin
                        tick_next = tick_inc;
                        if (sts.sample_hit) begin
                            sampled_next = 1'b1;
                        end
                        if (tick_inc == done_at) begin
                            csr_next[sar_pkg::BIT_IF] = 1'b1;
                            csr_next[sar_pkg::BIT_SC] = 1'b0;
                            conv_next    = 1'b0;
                            sampled_next = 1'b0;
                        end
                    end
                end
                sar_pkg::MODE_ACK: begin
                    csr_next[sar_pkg::BIT_IF] = 1'b0;
                end
                default: ;
            endcase
            irq_next = csr_next[sar_pkg::BIT_IE] & csr_next[sar_pkg::BIT_IF];
        end

        // Operands latched on the sampling tick; divisor pre-shifted by the code width
        if (cmd.div_load) begin
            rem_next  = {volts, sar_pkg::NUM_SHIFT'(0)};
            dvs_next  = {ref_uv[sar_pkg::UV_W-1:1], sar_pkg::CODE_W'(0)};
            quo_next  = '0;
            left_next = mux_reg[sar_pkg::BIT_LEFT];
        end

        if (cmd.div_step) begin
            if (rem_ge) begin
                rem_next = rem_reg - dvs_reg;
            end
            dvs_next = dvs_reg >> 1;
            quo_next = quo_fin;
        end

        if (cmd.div_last) begin
            result_next = left_reg ? {code, sar_pkg::LJ_SHIFT'(0)}
                                   : {sar_pkg::LJ_SHIFT'(0), code};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aref_reg    <= sar_pkg::AREF_RESET;
            avcc_reg    <= sar_pkg::AVCC_RESET;
            result_reg  <= '0;
            csr_reg     <= '0;
            ctrlb_reg   <= '0;
            mux_reg     <= '0;
            tick_reg    <= '0;
            div_reg     <= DW'(2);
            conv_reg    <= 1'b0;
            sampled_reg <= 1'b0;
        end else begin
            aref_reg    <= aref_next;
            avcc_reg    <= avcc_next;
            result_reg  <= result_next;
            csr_reg     <= csr_next;
            ctrlb_reg   <= ctrlb_next;
            mux_reg     <= mux_next;
            tick_reg    <= tick_next;
            div_reg     <= div_next;
            conv_reg    <= conv_next;
            sampled_reg <= sampled_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quo_reg  <= quo_next;
        left_reg <= left_next;
        rd_reg   <= rd_next;
        irq_reg  <= irq_next;
    end

    assign m_read_data = rd_reg;
    assign m_irq       = irq_reg;

endmodule

`default_nettype wire

FILE: rtl/sar_adc_register_model_top.sv
`timescale 1ns / 1ps
`default_nettype none

// 10-bit SAR ADC register model. Each request on the s_ channel is a
// register read, a register write, one ADC input-clock tick or an
// interrupt acknowledge; each produces exactly one response on the m_
// channel carrying the read byte (zero for anything but a read) and the
// interrupt level (IE AND IF after the request). Requests are taken one
// per cycle through a single response register: a new request is accepted
// when that register is empty or in the same cycle its response is taken.
// The exception is the sampling tick of a conversion: it launches a
// restoring divider that works out 512*uV/(ref/2) one quotient bit per
// cycle, so s_ready stays low while the divider runs (its own response
// still goes out at once). Conversion results are therefore in place
// long before the conversion completes. The two reference registers are
// written through the cfg_ port, which is always ready; write them only
// when the block is idle.

module sar_adc_register_model_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [sar_pkg::MODE_W-1:0]        s_mode,
    input  wire logic [sar_pkg::ADDR_W-1:0]        s_reg_addr,
    input  wire logic [sar_pkg::DATA_W-1:0]        s_write_data,
    input  wire logic [sar_pkg::UV_W-1:0]          s_channel_uvolt,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [sar_pkg::DATA_W-1:0]             m_read_data,
    output logic                                   m_irq,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sar_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sar_pkg::UV_W-1:0]          cfg_wdata
);

    sar_pkg::cmd_t    cmd;
    sar_pkg::status_t sts;

    // Reference registers take a write in any cycle
    assign cfg_ready = 1'b1;

    // Handshake sequencing and divider step count
    sar_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Register file, conversion timing and the divider
    sar_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_mode          (s_mode),
        .s_reg_addr      (s_reg_addr),
        .s_write_data    (s_write_data),
        .s_channel_uvolt (s_channel_uvolt),
        .cfg_we          (cfg_valid & cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .cmd             (cmd),
        .sts             (sts),
        .m_read_data     (m_read_data),
        .m_irq           (m_irq)
    );

endmodule

`default_nettype wire

FILE: bench/sar_adc_reply_checker.sv
`timescale 1ns / 1ps

// Watches the request, reply and reference-write channels, keeps its own
// copy of the ADC register state and compares each reply in order.
module sar_adc_reply_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic [sar_pkg::MODE_W-1:0]    s_mode,
    input  wire logic [sar_pkg::ADDR_W-1:0]    s_reg_addr,
    input  wire logic [sar_pkg::DATA_W-1:0]    s_write_data,
    input  wire logic [sar_pkg::UV_W-1:0]      s_channel_uvolt,

    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [sar_pkg::DATA_W-1:0]    m_read_data,
    input  wire logic                          m_irq,

    input  wire logic                          cfg_valid,
    input  wire logic                          cfg_ready,
    input  wire logic [sar_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sar_pkg::UV_W-1:0]      cfg_wdata,

    output int                                 fail_count,
    output int                                 replies_owed
);

    typedef struct packed {
        logic [sar_pkg::DATA_W-1:0] read_data;
        logic                       irq;
    } reply_t;

    reply_t owed_q[$];

    // register image
    logic [sar_pkg::UV_W-1:0]   aref_level;
    logic [sar_pkg::UV_W-1:0]   avcc_level;
    logic [sar_pkg::RES_W-1:0]  result_reg;
    logic [7:0]                 csr_reg;
    logic [7:0]                 ctrlb_reg;
    logic [7:0]                 mux_reg;
    logic [sar_pkg::TICK_W-1:0] tick_cnt;
    logic [7:0]                 clk_div;
    logic                       busy;
    logic                       have_sample;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < 50)
            $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    // One request against the register image; returns the reply it owes.
    task automatic apply_request(input sar_pkg::mode_t mode,
                                 input logic [sar_pkg::ADDR_W-1:0] addr,
                                 input logic [sar_pkg::DATA_W-1:0] wdata,
                                 input logic [sar_pkg::UV_W-1:0] uv, output reply_t r);
        logic [63:0] volts;
        logic [63:0] span;
        logic [63:0] code;
        logic [7:0]  nv;
        int          div_i;
        r.read_data = '0;
        case (mode)
            sar_pkg::MODE_READ: begin
                case (addr)
                    sar_pkg::ADDR_RES_LO: r.read_data = result_reg[7:0];
                    sar_pkg::ADDR_RES_HI: r.read_data = result_reg[15:8];
                    sar_pkg::ADDR_CSR:    r.read_data = csr_reg;
                    sar_pkg::ADDR_CTRLB:  r.read_data = ctrlb_reg;
                    sar_pkg::ADDR_MUX:    r.read_data = mux_reg;
                    default:              r.read_data = '0;
                endcase
            end
            sar_pkg::MODE_WRITE: begin
                case (addr)
                    sar_pkg::ADDR_CSR: begin
                        // flag is write-one-to-clear, start bit is owned here
                        nv = wdata;
                        nv[sar_pkg::BIT_SC] = 1'b0;
                        nv[sar_pkg::BIT_IF] = csr_reg[sar_pkg::BIT_IF] &
                                              ~wdata[sar_pkg::BIT_IF];
                        if (!wdata[sar_pkg::BIT_EN]) begin
                            busy = 1'b0;
                            have_sample = 1'b0;
                        end else if (busy) begin
                            nv[sar_pkg::BIT_SC] = 1'b1;
                        end else if (wdata[sar_pkg::BIT_SC]) begin
                            clk_div = (wdata[2:0] == 3'd0) ? 8'd2 : (8'd1 << wdata[2:0]);
                            tick_cnt = '0;
                            busy = 1'b1;
                            have_sample = 1'b0;
                            nv[sar_pkg::BIT_SC] = 1'b1;
                        end
                        csr_reg = nv;
                    end
                    sar_pkg::ADDR_CTRLB: ctrlb_reg = wdata;
                    sar_pkg::ADDR_MUX:   mux_reg = wdata;
                    default:    ;
                endcase
            end
            sar_pkg::MODE_TICK: begin
                if (busy) begin
                    div_i = clk_div;
                    tick_cnt = tick_cnt + 1'b1;
                    if (!have_sample && int'(tick_cnt) == (3 * div_i) / 2) begin
                        volts = (mux_reg[4:0] <= sar_pkg::MAX_CHANNEL) ? 64'(uv) : 64'd0;
                        case (sar_pkg::refs_t'(mux_reg[7:6]))
                            sar_pkg::REFS_EXT: span = 64'(aref_level);
                            sar_pkg::REFS_VCC: span = 64'(avcc_level);
                            sar_pkg::REFS_1V1: span = 64'(sar_pkg::REF_1V1);
                            default:           span = 64'(sar_pkg::REF_2V56);
                        endcase
                        span = span >> 1;
                        code = (span == 64'd0) ? 64'(sar_pkg::MAX_CODE)
                                               : (volts << sar_pkg::NUM_SHIFT) / span;
                        if (code > 64'(sar_pkg::MAX_CODE))
                            code = 64'(sar_pkg::MAX_CODE);
                        result_reg = mux_reg[sar_pkg::BIT_LEFT]
                                   ? sar_pkg::RES_W'(code << sar_pkg::LJ_SHIFT)
                                   : sar_pkg::RES_W'(code);
                        have_sample = 1'b1;
                    end
                    if (int'(tick_cnt) == 13 * div_i) begin
                        csr_reg[sar_pkg::BIT_IF] = 1'b1;
                        csr_reg[sar_pkg::BIT_SC] = 1'b0;
                        busy = 1'b0;
                        have_sample = 1'b0;
                    end
                end
            end
            default: csr_reg[sar_pkg::BIT_IF] = 1'b0;
        endcase
        r.irq = csr_reg[sar_pkg::BIT_IE] & csr_reg[sar_pkg::BIT_IF];
    endtask

    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            aref_level  = sar_pkg::AREF_RESET;
            avcc_level  = sar_pkg::AVCC_RESET;
            result_reg  = '0;
            csr_reg     = '0;
            ctrlb_reg   = '0;
            mux_reg     = '0;
            tick_cnt    = '0;
            clk_div     = 8'd2;
            busy        = 1'b0;
            have_sample = 1'b0;
            owed_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == sar_pkg::CFG_AREF)
                    aref_level = cfg_wdata;
                else
                    avcc_level = cfg_wdata;
            end
            // queue the new request first so a same-cycle reply finds it
            if (s_valid && s_ready) begin
                apply_request(sar_pkg::mode_t'(s_mode), s_reg_addr, s_write_data,
                              s_channel_uvolt, want);
                owed_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    report_mismatch("reply with nothing pending", 32'(m_read_data), '0);
                end else begin
                    want = owed_q.pop_front();
                    if (m_read_data !== want.read_data)
                        report_mismatch("read_data", 32'(m_read_data), 32'(want.read_data));
                    if (m_irq !== want.irq)
                        report_mismatch("irq", 32'(m_irq), 32'(want.irq));
                end
            end
        end
        replies_owed <= owed_q.size();
    end

endmodule

FILE: bench/tb_sar_adc_register_model_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the SAR ADC register block. Prediction and
// comparison live in sar_adc_reply_checker, which sits beside the block
// on the same wires and hands back its failure count.
module tb_sar_adc_register_model_top;

    localparam int RESET_CYCLES = 8;
    localparam int DIV_SETTLE   = 16;   // covers the divider pass after the sampling tick
    localparam int HOLD_CYCLES  = 300;  // long receiver hold-off
    localparam int STALL_LIMIT  = 2000; // cycles with no handshake before giving up
    localparam int PHASE_QUOTA  = 50;   // request quota for the small-prescaler part of each phase

    logic                          aclk;
    logic                          aresetn;

    logic                          s_valid;
    logic                          s_ready;
    logic [sar_pkg::MODE_W-1:0]    s_mode;
    logic [sar_pkg::ADDR_W-1:0]    s_reg_addr;
    logic [sar_pkg::DATA_W-1:0]    s_write_data;
    logic [sar_pkg::UV_W-1:0]      s_channel_uvolt;

    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [sar_pkg::DATA_W-1:0]    m_read_data;
    logic                          m_irq;

    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [sar_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sar_pkg::UV_W-1:0]      cfg_wdata;

    int check_failures;
    int replies_owed;

    // run bookkeeping
    int requests_sent;
    int conversions_run;
    int send_idle_pct;
    int recv_stall_pct;
    int holds_asked;
    int holds_served;
    int hold_left;
    int idle_cycles;

    // last reference values written, used to aim tick voltages
    logic [sar_pkg::UV_W-1:0] cur_aref;
    logic [sar_pkg::UV_W-1:0] cur_avcc;

    sar_adc_register_model_top i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_reg_addr      (s_reg_addr),
        .s_write_data    (s_write_data),
        .s_channel_uvolt (s_channel_uvolt),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_irq           (m_irq),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    sar_adc_reply_checker i_replies (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_reg_addr      (s_reg_addr),
        .s_write_data    (s_write_data),
        .s_channel_uvolt (s_channel_uvolt),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_irq           (m_irq),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .fail_count      (check_failures),
        .replies_owed    (replies_owed)
    );

    // 50 MHz clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Receiver: random stalls at recv_stall_pct, plus a one-off long
    // hold-off whenever the stimulus asks for one. The hold is counted
    // here so that the sender keeps offering requests meanwhile.
    always @(posedge aclk) begin
        if (holds_served < holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one request. A gap (valid low) is taken first, at random; valid is
    // never dropped at the end so back-to-back requests keep it high.
    task automatic send_request(input sar_pkg::mode_t mode,
                                input logic [sar_pkg::ADDR_W-1:0] addr,
                                input logic [sar_pkg::DATA_W-1:0] wdata,
                                input logic [sar_pkg::UV_W-1:0] uv);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_valid         <= 1'b1;
        s_mode          <= mode;
        s_reg_addr      <= addr;
        s_write_data    <= wdata;
        s_channel_uvolt <= uv;
        @(posedge aclk);
        while (s_ready !== 1'b1)
            @(posedge aclk);
        requests_sent++;
    endtask

    // Fully random request: any mode, any address (including the unused ones).
    task automatic send_noise();
        send_request(sar_pkg::mode_t'($urandom_range(3)), sar_pkg::ADDR_W'($urandom_range(7)),
                     sar_pkg::DATA_W'($urandom), sar_pkg::UV_W'($urandom));
    endtask

    // Drop valid, wait for every reply, then let the divider finish its pass.
    task automatic wait_idle();
        s_valid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (replies_owed != 0)
            @(posedge aclk);
        repeat (DIV_SETTLE) @(posedge aclk);
    endtask

    // Both reference registers in one burst; valid stays up between them.
    task automatic set_references(input logic [sar_pkg::UV_W-1:0] aref,
                                  input logic [sar_pkg::UV_W-1:0] avcc);
        cur_aref = aref;
        cur_avcc = avcc;
        cfg_valid <= 1'b1;
        cfg_index <= sar_pkg::CFG_AREF;
        cfg_wdata <= aref;
        @(posedge aclk);
        while (cfg_ready !== 1'b1)
            @(posedge aclk);
        cfg_index <= sar_pkg::CFG_AVCC;
        cfg_wdata <= avcc;
        @(posedge aclk);
        while (cfg_ready !== 1'b1)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // A well-formed conversion: disable, pick channel and reference, start
    // with the given prescaler, tick through the whole conversion with the
    // odd stray request mixed in, then read back and often clear the flag.
    task automatic run_conversion(input logic [2:0] sel);
        logic [7:0]               mux_val;
        logic [7:0]               csr_val;
        logic [sar_pkg::UV_W-1:0] span;
        logic [sar_pkg::UV_W-1:0] uv;
        int                       ticks;
        int                       done_ticks;
        conversions_run++;
        // mostly real channels, sometimes the ones that read as ground
        mux_val = (8'($urandom) & 8'hE0) |
                  (($urandom_range(5) == 0) ? 8'($urandom_range(31, 7)) : 8'($urandom_range(6)));
        case (sar_pkg::refs_t'(mux_val[7:6]))
            sar_pkg::REFS_EXT: span = cur_aref;
            sar_pkg::REFS_VCC: span = cur_avcc;
            sar_pkg::REFS_1V1: span = sar_pkg::REF_1V1;
            default:           span = sar_pkg::REF_2V56;
        endcase
        // EN low aborts anything left running; random flag bit tests clear-on-one
        send_request(sar_pkg::MODE_WRITE, sar_pkg::ADDR_CSR,
                     sar_pkg::DATA_W'($urandom) & 8'h3F, sar_pkg::UV_W'($urandom));
        send_request(sar_pkg::MODE_WRITE, sar_pkg::ADDR_MUX, mux_val, sar_pkg::UV_W'($urandom));
        csr_val = 8'hC0 | (8'($urandom) & 8'h38) | 8'(sel);
        send_request(sar_pkg::MODE_WRITE, sar_pkg::ADDR_CSR, csr_val, sar_pkg::UV_W'($urandom));
        ticks = 13 * ((sel == 3'd0) ? 2 : (1 << sel));
        done_ticks = 0;
        while (done_ticks < ticks) begin
            if ($urandom_range(9) == 0) begin
                send_noise();
            end else begin
                // aim most voltages inside the reference span, some anywhere
                uv = ($urandom_range(3) == 0) ? sar_pkg::UV_W'($urandom)
                                              : sar_pkg::UV_W'($urandom_range(span));
                send_request(sar_pkg::MODE_TICK, sar_pkg::ADDR_W'($urandom),
                             sar_pkg::DATA_W'($urandom), uv);
                done_ticks++;
            end
        end
        send_request(sar_pkg::MODE_READ, sar_pkg::ADDR_RES_LO, sar_pkg::DATA_W'($urandom),
                     sar_pkg::UV_W'($urandom));
        send_request(sar_pkg::MODE_READ, sar_pkg::ADDR_RES_HI, sar_pkg::DATA_W'($urandom),
                     sar_pkg::UV_W'($urandom));
        send_request(sar_pkg::MODE_READ, sar_pkg::ADDR_CSR, sar_pkg::DATA_W'($urandom),
                     sar_pkg::UV_W'($urandom));
        case ($urandom_range(2))
            0: send_request(sar_pkg::MODE_ACK, sar_pkg::ADDR_W'($urandom),
                            sar_pkg::DATA_W'($urandom), sar_pkg::UV_W'($urandom));
            1: send_request(sar_pkg::MODE_WRITE, sar_pkg::ADDR_CSR, (csr_val & 8'hAF) | 8'h10,
                            sar_pkg::UV_W'($urandom));
            default: ;
        endcase
        send_request(sar_pkg::MODE_READ, sar_pkg::ADDR_CSR, sar_pkg::DATA_W'($urandom),
                     sar_pkg::UV_W'($urandom));
    endtask

    // One random phase: the listed slow prescalers once each, then small
    // prescaler conversions and short noise bursts until the quota is met.
    task automatic run_phase(input int big_lo, input int big_hi);
        int stop_at;
        for (int sel = big_lo; sel <= big_hi; sel++)
            run_conversion(3'(sel));
        stop_at = requests_sent + PHASE_QUOTA;
        while (requests_sent < stop_at) begin
            if ($urandom_range(4) != 0)
                run_conversion(($urandom_range(7) == 0) ? 3'd3 : 3'($urandom_range(2)));
            else
                repeat ($urandom_range(8, 1)) send_noise();
        end
    endtask

    initial begin
        // every input known from time zero
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_mode          = sar_pkg::MODE_READ;
        s_reg_addr      = sar_pkg::ADDR_RES_LO;
        s_write_data    = '0;
        s_channel_uvolt = '0;
        cfg_valid       = 1'b0;
        cfg_index       = sar_pkg::CFG_AREF;
        cfg_wdata       = '0;
        requests_sent   = 0;
        conversions_run = 0;
        holds_asked     = 0;
        holds_served    = 0;
        hold_left       = 0;
        idle_cycles     = 0;
        send_idle_pct   = 24;
        recv_stall_pct  = 68;
        cur_aref        = sar_pkg::AREF_RESET;
        cur_avcc        = sar_pkg::AVCC_RESET;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // References at opposite extremes: AVCC of 2 uV gives a half
        // reference of one, so 1 uV lands exactly on mid-scale.
        set_references(sar_pkg::UV_W'(8388607), sar_pkg::UV_W'(2));

        // --- directed cases ---
        send_request(sar_pkg::MODE_READ,  sar_pkg::ADDR_CSR,    sar_pkg::DATA_W'($urandom),
                     sar_pkg::UV_W'($urandom));
        // AVCC reference, left-justified, channel 0
        send_request(sar_pkg::MODE_WRITE, sar_pkg::ADDR_MUX,    8'h60, sar_pkg::UV_W'($urandom));
        // enable, start, interrupt enable, prescaler select 0 (divide by 2)
        send_request(sar_pkg::MODE_WRITE, sar_pkg::ADDR_CSR,    8'hC8, sar_pkg::UV_W'($urandom));
        send_request(sar_pkg::MODE_TICK,  sar_pkg::ADDR_RES_LO, 8'h00, sar_pkg::UV_W'(8388607));
        send_request(sar_pkg::MODE_TICK,  sar_pkg::ADDR_RES_LO, 8'hFF, sar_pkg::UV_W'(8388607));
        // third tick is the sampling point: mid-scale, shifted up
        send_request(sar_pkg::MODE_TICK,  sar_pkg::ADDR_RES_LO, 8'h00, sar_pkg::UV_W'(1));
        send_request(sar_pkg::MODE_READ,  sar_pkg::ADDR_RES_HI, sar_pkg::DATA_W'($urandom),
                     sar_pkg::UV_W'($urandom));
        send_request(sar_pkg::MODE_READ,  sar_pkg::ADDR_RES_LO, sar_pkg::DATA_W'($urandom),
                     sar_pkg::UV_W'($urandom));
        // start bit low and prescaler 7 while busy: no restart, divider kept
        send_request(sar_pkg::MODE_WRITE, sar_pkg::ADDR_CSR,    8'h8F, sar_pkg::UV_W'($urandom));
        send_request(sar_pkg::MODE_READ,  sar_pkg::ADDR_CSR,    sar_pkg::DATA_W'($urandom),
                     sar_pkg::UV_W'($urandom));
        // enable low aborts the conversion and clears the start bit
        send_request(sar_pkg::MODE_WRITE, sar_pkg::ADDR_CSR,    8'h28, sar_pkg::UV_W'($urandom));
        // control B and auto-trigger bit are plain storage
        send_request(sar_pkg::MODE_WRITE, sar_pkg::ADDR_CTRLB,  8'hFF, sar_pkg::UV_W'($urandom));
        send_request(sar_pkg::MODE_READ,  sar_pkg::ADDR_CTRLB,  sar_pkg::DATA_W'($urandom),
                     sar_pkg::UV_W'($urandom));
        // 2.56 V reference, right-justified, channel 7 reads as ground
        send_request(sar_pkg::MODE_WRITE, sar_pkg::ADDR_MUX,    8'hC7, sar_pkg::UV_W'($urandom));
        send_request(sar_pkg::MODE_WRITE, sar_pkg::ADDR_CSR,    8'hE8, sar_pkg::UV_W'($urandom));
        send_request(sar_pkg::MODE_TICK,  sar_pkg::ADDR_MUX,    8'h00, sar_pkg::UV_W'(8388607));
        send_request(sar_pkg::MODE_TICK,  sar_pkg::ADDR_MUX,    8'h00, sar_pkg::UV_W'(8388607));
        send_request(sar_pkg::MODE_TICK,  sar_pkg::ADDR_MUX,    8'h00, sar_pkg::UV_W'(8388607));
        send_request(sar_pkg::MODE_READ,  sar_pkg::ADDR_RES_LO, sar_pkg::DATA_W'($urandom),
                     sar_pkg::UV_W'($urandom));
        // result registers are read-only, upper addresses are holes
        send_request(sar_pkg::MODE_WRITE, sar_pkg::ADDR_RES_LO, 8'hFF, sar_pkg::UV_W'($urandom));
        send_request(sar_pkg::MODE_WRITE, sar_pkg::ADDR_W'(7),  8'hFF, sar_pkg::UV_W'($urandom));
        send_request(sar_pkg::MODE_READ,  sar_pkg::ADDR_W'(5),  sar_pkg::DATA_W'($urandom),
                     sar_pkg::UV_W'($urandom));
        send_request(sar_pkg::MODE_READ,  sar_pkg::ADDR_MUX,    sar_pkg::DATA_W'($urandom),
                     sar_pkg::UV_W'($urandom));
        send_request(sar_pkg::MODE_ACK,   sar_pkg::ADDR_CSR,    sar_pkg::DATA_W'($urandom),
                     sar_pkg::UV_W'($urandom));
        // disable with the flag bit written as one
        send_request(sar_pkg::MODE_WRITE, sar_pkg::ADDR_CSR,    8'h10, sar_pkg::UV_W'($urandom));
        wait_idle();

        // --- phase A: reset references, sender idles lightly, receiver heavily ---
        set_references(sar_pkg::AREF_RESET, sar_pkg::AVCC_RESET);
        run_phase(3, 3);
        wait_idle();

        // --- phase B: random references, idling the other way round ---
        set_references(sar_pkg::UV_W'($urandom_range(8388607, 2)),
                       sar_pkg::UV_W'($urandom_range(8388607, 2)));
        send_idle_pct  = 68;
        recv_stall_pct = 24;
        run_phase(2, 2);
        wait_idle();

        // --- phase C: swapped extremes, no idling, one long receiver hold ---
        set_references(sar_pkg::UV_W'(2), sar_pkg::UV_W'(8388607));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holds_asked++;
        run_phase(1, 1);
        wait_idle();

        $display("Summary: %0d requests, %0d conversions over prescaler selects 0 to 3,",
                 requests_sent, conversions_run);
        $display("  references at both extremes, reset and random; %0d-cycle reply hold-off.",
                 HOLD_CYCLES);
        if (check_failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sar_adc_register_model_top.f
rtl/sar_pkg.sv
rtl/sar_ctrl.sv
rtl/sar_dp.sv
rtl/sar_adc_register_model_top.sv
bench/sar_adc_reply_checker.sv
bench/tb_sar_adc_register_model_top.sv
